FILE: hw/rtl/xor_checked_frame_receiver_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the frame receiver checker
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKED_FRAME_RECEIVER_CORE_ASSERT_SVH
`define XOR_CHECKED_FRAME_RECEIVER_CORE_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define XCFR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xcfr assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define XCFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xcfr assertion failed");

`endif

FILE: hw/rtl/xcfr_pkg.sv
// ----------------------------------------------------------------------------
// xcfr_pkg
// Shared types and constants of the start/length/XOR frame receiver.
// ----------------------------------------------------------------------------
package xcfr_pkg;

  localparam int unsigned CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHECK_SEED   = 8'd1;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_DATA  = 2'd1,
    PH_CHECK = 2'd2,
    PH_DRAIN = 2'd3
  } phase_t;

  // controller -> datapath
  typedef struct packed {
    logic start_frame;
    logic store_byte;
    logic load_read;
    logic advance_read;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_start;
    logic buf_full;
    logic frame_done;
    logic check_match;
    logic payload_empty;
    logic first_last;
    logic next_last;
  } dp_status_t;

endpackage

FILE: hw/rtl/xcfr_rx_if.sv
// ----------------------------------------------------------------------------
// xcfr_rx_if
// Received-byte channel: one byte per beat.
// ----------------------------------------------------------------------------
interface xcfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/xcfr_res_if.sv
// ----------------------------------------------------------------------------
// xcfr_res_if
// Result channel: status, payload byte and run marker per beat.
// ----------------------------------------------------------------------------
interface xcfr_res_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic       has_byte;
  logic [7:0] payload_byte;
  logic       last;

  modport source (output valid, output status, output has_byte, output payload_byte,
                  output last, input ready);
  modport sink   (input valid, input status, input has_byte, input payload_byte,
                  input last, output ready);
endinterface

FILE: hw/rtl/xcfr_cfg_if.sv
// ----------------------------------------------------------------------------
// xcfr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface xcfr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [xcfr_pkg::CFG_INDEX_W-1:0] index;
  logic [7:0]                       wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: hw/rtl/xcfr_datapath.sv
// ----------------------------------------------------------------------------
// xcfr_datapath
// Frame store, fill count, running XOR check, readout pointer and config regs.
// ----------------------------------------------------------------------------
module xcfr_datapath #(
  parameter int unsigned BUFFER_BYTES = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [7:0]                       rx_byte,
  input  logic                             cfg_we,
  input  logic [xcfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_wdata,
  input  xcfr_pkg::dp_cmd_t                cmd,
  output xcfr_pkg::dp_status_t             stat,
  output logic [7:0]                       rd_data
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned FW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned CW = (FW + 1 > 9) ? FW + 1 : 9;

  logic [7:0]    start_marker;
  logic [7:0]    check_seed;
  logic [FW-1:0] fill_count;
  logic [7:0]    running_check;
  logic [7:0]    frame_len;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    len_now;
  logic [7:0]    frame_store [BUFFER_BYTES];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= '0;
      check_seed   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == xcfr_pkg::REG_START_MARKER) begin
        start_marker <= cfg_wdata;
      end else if (cfg_index == xcfr_pkg::REG_CHECK_SEED) begin
        check_seed <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      running_check <= '0;
    end else if (cmd.start_frame) begin
      fill_count    <= '0;
      running_check <= check_seed;
    end else if (cmd.store_byte) begin
      fill_count <= fill_count + FW'(1);
      if (fill_count != '0) begin
        running_check <= running_check ^ rx_byte;
      end
    end
  end

  // entry 0 of the store is the length byte; keep a copy for the compare
  always_ff @(posedge clk) begin
    if (cmd.store_byte && fill_count == '0) begin
      frame_len <= rx_byte;
    end
  end

  always_comb begin
    if (cmd.load_read) begin
      rd_addr = AW'(1);
    end else if (cmd.advance_read) begin
      rd_addr = rd_ptr + AW'(1);
    end else begin
      rd_addr = rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      frame_store[fill_count[AW-1:0]] <= rx_byte;
    end
    rd_data <= frame_store[rd_addr];
  end

  assign len_now = (fill_count == '0) ? rx_byte : frame_len;

  always_comb begin
    stat.is_start      = (rx_byte == start_marker);
    stat.buf_full      = (fill_count == FW'(BUFFER_BYTES));
    stat.frame_done    = (CW'(fill_count) + CW'(1) == CW'(len_now));
    stat.check_match   = (rx_byte == running_check);
    stat.payload_empty = (fill_count <= FW'(1));
    stat.first_last    = (fill_count == FW'(2));
    stat.next_last     = (CW'(rd_ptr) + CW'(2) == CW'(fill_count));
  end

endmodule

FILE: hw/rtl/xcfr_ctrl.sv
// ----------------------------------------------------------------------------
// xcfr_ctrl
// Frame parser state machine and result register control.
// ----------------------------------------------------------------------------
module xcfr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rx_valid,
  output logic                 rx_ready,
  input  logic                 res_ready,
  output logic                 res_valid,
  output logic                 res_status,
  output logic                 res_has_byte,
  output logic                 res_last,
  input  xcfr_pkg::dp_status_t stat,
  output xcfr_pkg::dp_cmd_t    cmd
);

  xcfr_pkg::phase_t state;
  xcfr_pkg::phase_t state_next;
  logic             res_valid_next;
  logic             res_status_next;
  logic             res_has_byte_next;
  logic             res_last_next;
  logic             in_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= xcfr_pkg::PH_HUNT;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res_status   <= res_status_next;
    res_has_byte <= res_has_byte_next;
    res_last     <= res_last_next;
  end

  assign rx_ready = (state != xcfr_pkg::PH_DRAIN) && (!res_valid || res_ready);
  assign in_acc   = rx_valid && rx_ready;

  always_comb begin
    state_next        = state;
    res_valid_next    = res_valid && !res_ready;
    res_status_next   = res_status;
    res_has_byte_next = res_has_byte;
    res_last_next     = res_last;
    cmd               = '0;
    case (state)
      xcfr_pkg::PH_HUNT: begin
        if (in_acc) begin
          if (stat.is_start) begin
            cmd.start_frame = 1'b1;
            state_next      = xcfr_pkg::PH_DATA;
          end else begin
            res_valid_next    = 1'b1;
            res_status_next   = 1'b1;
            res_has_byte_next = 1'b0;
            res_last_next     = 1'b1;
          end
        end
      end
      xcfr_pkg::PH_DATA: begin
        if (in_acc) begin
          if (stat.buf_full) begin
            // drop the byte and go back to hunting
            res_valid_next    = 1'b1;
            res_status_next   = 1'b1;
            res_has_byte_next = 1'b0;
            res_last_next     = 1'b1;
            state_next        = xcfr_pkg::PH_HUNT;
          end else begin
            cmd.store_byte = 1'b1;
            if (stat.frame_done) begin
              state_next = xcfr_pkg::PH_CHECK;
            end
          end
        end
      end
      xcfr_pkg::PH_CHECK: begin
        if (in_acc) begin
          res_valid_next    = 1'b1;
          res_has_byte_next = 1'b0;
          res_last_next     = 1'b1;
          state_next        = xcfr_pkg::PH_HUNT;
          if (!stat.check_match) begin
            res_status_next = 1'b1;
          end else if (stat.payload_empty) begin
            res_status_next = 1'b0;
          end else begin
            // start payload readout at entry 1
            cmd.load_read     = 1'b1;
            res_status_next   = 1'b0;
            res_has_byte_next = 1'b1;
            res_last_next     = stat.first_last;
            state_next        = xcfr_pkg::PH_DRAIN;
          end
        end
      end
      xcfr_pkg::PH_DRAIN: begin
        if (res_ready) begin
          if (res_last) begin
            state_next = xcfr_pkg::PH_HUNT;
          end else begin
            cmd.advance_read  = 1'b1;
            res_valid_next    = 1'b1;
            res_has_byte_next = 1'b1;
            res_last_next     = stat.next_last;
          end
        end
      end
      default: begin
        state_next = xcfr_pkg::PH_HUNT;
      end
    endcase
  end

endmodule

FILE: hw/rtl/xor_checked_frame_receiver_core.sv
// A result beat is registered and shows in the cycle after the byte causing it.
// Throughput: one byte per cycle in hunt, store or check while no result waits.
// A checked payload of n bytes streams out of the frame store read port at one
// beat per cycle while res.ready is high; received bytes stall until it ends.
// Reset (rst, synchronous): hunting for the start byte, both config registers zero,
// no result pending; the frame store is not cleared.
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_core
// Start/length/XOR-checksum deframer: top level joining controller and datapath.
// ----------------------------------------------------------------------------
module xor_checked_frame_receiver_core #(
  parameter int unsigned BUFFER_BYTES = 32
) (
  input  logic  clk,
  input  logic  rst,
  xcfr_rx_if.sink    rx,
  xcfr_res_if.source res,
  xcfr_cfg_if.sink   cfg
);

  xcfr_pkg::dp_cmd_t    cmd;
  xcfr_pkg::dp_status_t stat;
  logic [7:0]           rd_data;
  logic                 res_has_byte;

  assign cfg.ready = 1'b1;

  xcfr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx.valid),
    .rx_ready     (rx.ready),
    .res_ready    (res.ready),
    .res_valid    (res.valid),
    .res_status   (res.status),
    .res_has_byte (res_has_byte),
    .res_last     (res.last),
    .stat         (stat),
    .cmd          (cmd)
  );

  xcfr_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx.rx_byte),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_wdata (cfg.wdata),
    .cmd       (cmd),
    .stat      (stat),
    .rd_data   (rd_data)
  );

  assign res.has_byte     = res_has_byte;
  assign res.payload_byte = res_has_byte ? rd_data : 8'd0;

endmodule

FILE: hw/rtl/xcfr_checker.sv
// ----------------------------------------------------------------------------
// xcfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "xor_checked_frame_receiver_core_assert.svh"

module xcfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       res_status,
  input logic       res_has_byte,
  input logic [7:0] res_payload_byte,
  input logic       res_last
);

  // hold a result until it is taken
  `XCFR_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)
  // payload beats only come from a checked frame
  `XCFR_ASSERT_SAME(a_byte_valid, clk, rst, res_valid && res_has_byte, !res_status)
  `XCFR_ASSERT_SAME(a_no_byte_zero, clk, rst, res_valid && !res_has_byte,
                    res_payload_byte == 8'd0)
  `XCFR_ASSERT_SAME(a_error_last, clk, rst, res_valid && res_status, res_last)
  // no new byte taken while a payload run is still streaming out
  `XCFR_ASSERT_SAME(a_run_stalls_rx, clk, rst, res_valid && res_has_byte && !res_last,
                    !rx_ready)

endmodule

bind xor_checked_frame_receiver_core xcfr_checker u_xcfr_checker (
  .clk              (clk),
  .rst              (rst),
  .rx_ready         (rx.ready),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_status       (res.status),
  .res_has_byte     (res.has_byte),
  .res_payload_byte (res.payload_byte),
  .res_last         (res.last)
);
